>>> rtl/core/rgrf_pkg.sv
// Shared constants and types of the recursive Gaussian row filter.
// No dependencies; every other file of the block uses it.
`default_nettype none

package rgrf_pkg;

  localparam int MAX_RADIUS  = 32;
  localparam int SAMPLE_BITS = 16;
  localparam int TDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8;

  localparam int COEF_W     = 25;
  localparam int FRAC_W     = 22;
  localparam int SEC_W      = 40;
  localparam int SEC_FRAC   = 16;
  localparam int FEED_SHIFT = FRAC_W - SEC_FRAC;
  localparam int SUM_W      = SAMPLE_BITS + 1;
  localparam int FEED_W     = COEF_W + SUM_W + 1 - FEED_SHIFT;
  localparam int NUM_SEC    = 3;

  localparam int RAD_W       = 6;
  localparam int R_W         = $clog2(MAX_RADIUS + 1);
  localparam int DELAY_DEPTH = 2 * MAX_RADIUS;
  localparam int PTR_W       = $clog2(DELAY_DEPTH);
  localparam int POS_CAP     = 2 * MAX_RADIUS;
  localparam int POS_W       = $clog2(POS_CAP + 1);

  localparam int CFG_IDX_W = 3;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
  localparam int OUT_W      = SAMPLE_BITS + 1;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [FEED_W-1:0] feed_t;
  typedef logic signed [SEC_W-1:0]  sec_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS = 3'd0,
    CFG_FEED_1 = 3'd1,
    CFG_FEED_3 = 3'd2,
    CFG_FEED_5 = 3'd3,
    CFG_FB_1   = 3'd4,
    CFG_FB_3   = 3'd5,
    CFG_FB_5   = 3'd6
  } cfg_reg_t;

  typedef enum logic {
    SEQ_TAKE,
    SEQ_FLUSH
  } seq_state_t;

  // step: a recurrence step is in the section stage this cycle
  // clear: previous step closed a row, section history reads as zero
  typedef struct packed {
    logic step;
    logic clear;
  } sec_ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/rgrf_section.sv
// One second-order recursive section: feedback multiply, history update, saturation.
// Depends on rgrf_pkg.
`default_nettype none

module rgrf_section (
  input  wire                    clk,
  input  wire rgrf_pkg::sec_ctl_t ctl,
  input  wire rgrf_pkg::feed_t   feed_term,
  input  wire rgrf_pkg::coef_t   fb_coef,
  output rgrf_pkg::sec_t         y_last
);

  localparam int VH_W   = rgrf_pkg::SEC_W - rgrf_pkg::SEC_FRAC;
  localparam int PH_W   = rgrf_pkg::COEF_W + VH_W;
  localparam int PL_W   = rgrf_pkg::COEF_W + rgrf_pkg::SEC_FRAC + 1;
  localparam int FULL_W = rgrf_pkg::COEF_W + rgrf_pkg::SEC_W + 1;
  localparam int FB_W   = FULL_W - rgrf_pkg::FRAC_W;
  localparam int Y_W    = FB_W + 2;
  localparam int SEC_W  = rgrf_pkg::SEC_W;

  localparam logic signed [FULL_W-1:0] HALF_LSB = FULL_W'(1) <<< (rgrf_pkg::FRAC_W - 1);

  rgrf_pkg::sec_t last_r;
  rgrf_pkg::sec_t prev_r;
  rgrf_pkg::sec_t y1;
  rgrf_pkg::sec_t y2;
  rgrf_pkg::sec_t y_sat;

  logic signed [VH_W-1:0]   vh;
  logic signed [rgrf_pkg::SEC_FRAC:0] vl;
  logic signed [PH_W-1:0]   ph;
  logic signed [PL_W-1:0]   pl;
  logic signed [FULL_W-1:0] full;
  logic signed [FB_W-1:0]   fb;
  logic signed [Y_W-1:0]    y;
  logic                     fits;

  always_comb begin
    y1   = ctl.clear ? '0 : last_r;
    y2   = ctl.clear ? '0 : prev_r;
    // split the 40-bit history so each product stays under 32x32
    vh   = y1[SEC_W-1:rgrf_pkg::SEC_FRAC];
    vl   = {1'b0, y1[rgrf_pkg::SEC_FRAC-1:0]};
    ph   = fb_coef * vh;
    pl   = fb_coef * vl;
    full = (FULL_W'(ph) <<< rgrf_pkg::SEC_FRAC) + FULL_W'(pl) + HALF_LSB;
    fb   = full[FULL_W-1:rgrf_pkg::FRAC_W];
    y    = Y_W'(feed_term) - Y_W'(fb) - Y_W'(y2);
    fits = (y[Y_W-1:SEC_W-1] == '0) || (y[Y_W-1:SEC_W-1] == '1);
    if (fits) begin
      y_sat = y[SEC_W-1:0];
    end else if (y[Y_W-1]) begin
      y_sat = {1'b1, {(SEC_W-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(SEC_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      prev_r <= y1;
      last_r <= y_sat;
    end
  end

  assign y_last = last_r;

endmodule

`default_nettype wire

>>> rtl/core/rgrf_out_fifo.sv
// Result queue between the filter pipeline and the output stream.
// Depends on rgrf_pkg; the writer guarantees room before it issues a step.
`default_nettype none

module rgrf_out_fifo (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           wr_en,
  input  wire [rgrf_pkg::OUT_W-1:0]     wr_data,
  output logic                          rd_valid,
  input  wire                           rd_ready,
  output logic [rgrf_pkg::OUT_W-1:0]    rd_data,
  output logic [rgrf_pkg::FIFO_CW-1:0]  level
);

  logic [rgrf_pkg::OUT_W-1:0]   mem_r [rgrf_pkg::FIFO_DEPTH];
  logic [rgrf_pkg::FIFO_AW-1:0] wr_ptr_r;
  logic [rgrf_pkg::FIFO_AW-1:0] rd_ptr_r;
  logic [rgrf_pkg::FIFO_CW-1:0] cnt_r;
  logic                         rd_en;

  assign rd_valid = (cnt_r != '0);
  assign rd_en    = rd_valid && rd_ready;
  assign rd_data  = mem_r[rd_ptr_r];
  assign level    = cnt_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/recursive_gaussian_row_filter.sv
// Top level of the recursive Gaussian row filter: step sequencer, sample delay line,
// feed stage, three sections and output rounding. Depends on rgrf_pkg, rgrf_section,
// rgrf_out_fifo.
//
//   channel | ports                                 | payload
//   input   | in_tvalid  in_tready  in_tdata  in_tlast | sample_in, row_end
//   output  | out_tvalid out_tready out_tdata out_tlast | sample_out, row_done
//   config  | cfg_valid  cfg_ready  cfg_index cfg_data  | 7 registers, always ready
//
// One recurrence step per cycle while the queue has room, set by the section loop;
// a sample takes one step, the row-end sample R steps (its own, then the flush
// steps) while in_tready stays low. Steps are registered through stages B, C, D.
// Reset clears control and config; the delay line is never cleared, reads are gated
// by row position. Results wait in an 8-entry queue; input and flush steps are held
// off when the queue plus the three steps in flight could overflow it.
`default_nettype none

module recursive_gaussian_row_filter (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_tvalid,
  output logic                            in_tready,
  input  wire [rgrf_pkg::TDATA_W-1:0]     in_tdata,   // [15:0] sample_in
  input  wire                             in_tlast,   // row_end
  output logic                            out_tvalid,
  input  wire                             out_tready,
  output logic [rgrf_pkg::TDATA_W-1:0]    out_tdata,  // [15:0] sample_out
  output logic                            out_tlast,  // row_done
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire [rgrf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [rgrf_pkg::COEF_W-1:0]      cfg_data
);

  localparam int SB    = rgrf_pkg::SAMPLE_BITS;
  localparam int R_W   = rgrf_pkg::R_W;
  localparam int PTR_W = rgrf_pkg::PTR_W;
  localparam int POS_W = rgrf_pkg::POS_W;
  localparam int KJ_W  = POS_W + 1;
  localparam int P_W   = rgrf_pkg::COEF_W + rgrf_pkg::SUM_W;
  localparam int T_W   = rgrf_pkg::SEC_W + 2;
  localparam int Q_W   = T_W - rgrf_pkg::SEC_FRAC;
  localparam int NS    = rgrf_pkg::NUM_SEC;
  localparam int CW    = rgrf_pkg::FIFO_CW;

  localparam logic signed [P_W:0] FEED_RND = (P_W + 1)'(1) <<< (rgrf_pkg::FEED_SHIFT - 1);
  localparam logic signed [T_W-1:0] OUT_RND = T_W'(1) <<< (rgrf_pkg::SEC_FRAC - 1);

  // configuration
  logic [rgrf_pkg::RAD_W-1:0] radius_r;
  rgrf_pkg::coef_t            feed_coef_r [NS];
  rgrf_pkg::coef_t            fb_coef_r   [NS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= rgrf_pkg::RAD_W'(1);
      for (int i = 0; i < NS; i++) begin
        feed_coef_r[i] <= '0;
        fb_coef_r[i]   <= '0;
      end
    end else if (cfg_valid) begin
      case (rgrf_pkg::cfg_reg_t'(cfg_index))
        rgrf_pkg::CFG_RADIUS: radius_r       <= cfg_data[rgrf_pkg::RAD_W-1:0];
        rgrf_pkg::CFG_FEED_1: feed_coef_r[0] <= cfg_data;
        rgrf_pkg::CFG_FEED_3: feed_coef_r[1] <= cfg_data;
        rgrf_pkg::CFG_FEED_5: feed_coef_r[2] <= cfg_data;
        rgrf_pkg::CFG_FB_1:   fb_coef_r[0]   <= cfg_data;
        rgrf_pkg::CFG_FB_3:   fb_coef_r[1]   <= cfg_data;
        rgrf_pkg::CFG_FB_5:   fb_coef_r[2]   <= cfg_data;
        default:              radius_r       <= radius_r;
      endcase
    end
  end

  logic [R_W-1:0] r_eff;
  logic [R_W:0]   two_r;

  always_comb begin
    if (radius_r == '0) begin
      r_eff = R_W'(1);
    end else if ({1'b0, radius_r} > (rgrf_pkg::RAD_W + 1)'(rgrf_pkg::MAX_RADIUS)) begin
      r_eff = R_W'(rgrf_pkg::MAX_RADIUS);
    end else begin
      r_eff = R_W'(radius_r);
    end
    two_r = {r_eff, 1'b0};
  end

  // step sequencer
  rgrf_pkg::seq_state_t state_r;
  rgrf_pkg::seq_state_t state_nxt;
  logic [R_W-1:0]   j_r;
  logic [POS_W-1:0] k_r;
  logic [PTR_W-1:0] fptr_r;
  logic [POS_W-1:0] pos_r;
  logic [PTR_W-1:0] ptr_r;

  logic             credit_ok;
  logic             in_xfer;
  logic             step_go;
  logic             done_cur;
  logic [R_W-1:0]   j_cur;
  logic [POS_W-1:0] k_cur;
  logic [PTR_W-1:0] p_cur;
  logic [SB-1:0]    right_cur;

  assign in_xfer = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rgrf_pkg::SEQ_TAKE: begin
        if (in_xfer && in_tlast && (r_eff != R_W'(1))) begin
          state_nxt = rgrf_pkg::SEQ_FLUSH;
        end
      end
      rgrf_pkg::SEQ_FLUSH: begin
        if (credit_ok && (j_r == R_W'(r_eff - R_W'(1)))) begin
          state_nxt = rgrf_pkg::SEQ_TAKE;
        end
      end
      default: state_nxt = rgrf_pkg::SEQ_TAKE;
    endcase
  end

  always_comb begin
    case (state_r)
      rgrf_pkg::SEQ_FLUSH: begin
        in_tready = 1'b0;
        step_go   = credit_ok;
        j_cur     = j_r;
        k_cur     = k_r;
        p_cur     = fptr_r;
        right_cur = '0;
        done_cur  = (j_r == R_W'(r_eff - R_W'(1)));
      end
      default: begin
        in_tready = credit_ok;
        step_go   = in_xfer;
        j_cur     = '0;
        k_cur     = pos_r;
        p_cur     = ptr_r;
        right_cur = in_tdata[SB-1:0];
        done_cur  = in_tlast && (r_eff == R_W'(1));
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rgrf_pkg::SEQ_TAKE;
      pos_r   <= '0;
      ptr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_xfer) begin
        if (in_tlast) begin
          pos_r <= '0;
          ptr_r <= '0;
        end else begin
          if (pos_r < POS_W'(rgrf_pkg::POS_CAP)) begin
            pos_r <= pos_r + 1'b1;
          end
          if (ptr_r == PTR_W'(rgrf_pkg::DELAY_DEPTH - 1)) begin
            ptr_r <= '0;
          end else begin
            ptr_r <= ptr_r + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == rgrf_pkg::SEQ_FLUSH) begin
      if (step_go) begin
        j_r <= j_r + 1'b1;
      end
    end else if (in_xfer) begin
      j_r    <= R_W'(1);
      k_r    <= pos_r;
      fptr_r <= ptr_r;
    end
  end

  // per-step decode
  logic [KJ_W-1:0]  kj;
  logic             use_left;
  logic             emit;
  logic [R_W:0]     lag;
  logic [PTR_W:0]   addr_w;
  logic [PTR_W-1:0] rd_addr;

  always_comb begin
    kj       = KJ_W'(k_cur) + KJ_W'(j_cur);
    use_left = kj >= KJ_W'(two_r);
    emit     = (kj + KJ_W'(1)) >= KJ_W'(r_eff);
    lag      = two_r - (R_W + 1)'(j_cur);
    addr_w   = (PTR_W + 1)'(p_cur) + (PTR_W + 1)'(rgrf_pkg::DELAY_DEPTH)
             - (PTR_W + 1)'(lag);
    if (addr_w >= (PTR_W + 1)'(rgrf_pkg::DELAY_DEPTH)) begin
      addr_w = addr_w - (PTR_W + 1)'(rgrf_pkg::DELAY_DEPTH);
    end
    rd_addr = addr_w[PTR_W-1:0];
  end

  // sample delay line, read before write
  logic signed [SB-1:0] dly_mem [rgrf_pkg::DELAY_DEPTH];
  logic signed [SB-1:0] dly_rd_r;

  always_ff @(posedge clk) begin
    dly_rd_r <= dly_mem[rd_addr];
    if (in_xfer) begin
      dly_mem[ptr_r] <= in_tdata[SB-1:0];
    end
  end

  // stage B: feed products
  logic                 vb_r;
  logic                 vc_r;
  logic                 vd_r;
  logic signed [SB-1:0] right_b_r;
  logic                 left_b_r;
  logic                 emit_b_r;
  logic                 done_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else begin
      vb_r <= step_go;
    end
  end

  always_ff @(posedge clk) begin
    right_b_r <= right_cur;
    left_b_r  <= use_left;
    emit_b_r  <= emit;
    done_b_r  <= done_cur;
  end

  logic signed [rgrf_pkg::SUM_W-1:0] in_sum;
  logic signed [SB-1:0]              left_b;
  logic signed [P_W-1:0]             feed_prod [NS];
  logic signed [P_W:0]               feed_rnd  [NS];
  rgrf_pkg::feed_t                   feed_c_r  [NS];
  logic                              emit_c_r;
  logic                              done_c_r;

  always_comb begin
    left_b = left_b_r ? dly_rd_r : '0;
    in_sum = rgrf_pkg::SUM_W'(left_b) + rgrf_pkg::SUM_W'(right_b_r);
    for (int i = 0; i < NS; i++) begin
      feed_prod[i] = feed_coef_r[i] * in_sum;
      feed_rnd[i]  = (P_W + 1)'(feed_prod[i]) + FEED_RND;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NS; i++) begin
      feed_c_r[i] <= feed_rnd[i][P_W:rgrf_pkg::FEED_SHIFT];
    end
    emit_c_r <= emit_b_r;
    done_c_r <= done_b_r;
  end

  // stage C: sections
  logic               clr_r;
  rgrf_pkg::sec_ctl_t sec_ctl;
  rgrf_pkg::sec_t     sec_y [NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r  <= 1'b0;
      vd_r  <= 1'b0;
      clr_r <= 1'b1;
    end else begin
      vc_r <= vb_r;
      vd_r <= vc_r;
      if (vc_r) begin
        clr_r <= done_c_r;
      end
    end
  end

  assign sec_ctl.step  = vc_r;
  assign sec_ctl.clear = clr_r;

  for (genvar g = 0; g < NS; g++) begin : g_sec
    rgrf_section u_sec (
      .clk       (clk),
      .ctl       (sec_ctl),
      .feed_term (feed_c_r[g]),
      .fb_coef   (fb_coef_r[g]),
      .y_last    (sec_y[g])
    );
  end

  // stage D: sum, round, saturate
  logic emit_d_r;
  logic done_d_r;

  always_ff @(posedge clk) begin
    emit_d_r <= emit_c_r;
    done_d_r <= done_c_r;
  end

  logic signed [T_W-1:0] total;
  logic signed [Q_W-1:0] q;
  logic signed [SB-1:0]  out_sat;

  always_comb begin
    total = '0;
    for (int i = 0; i < NS; i++) begin
      total = total + T_W'(sec_y[i]);
    end
    total = total + OUT_RND;
    q     = total[T_W-1:rgrf_pkg::SEC_FRAC];
    if ((q[Q_W-1:SB-1] == '0) || (q[Q_W-1:SB-1] == '1)) begin
      out_sat = q[SB-1:0];
    end else if (q[Q_W-1]) begin
      out_sat = {1'b1, {(SB-1){1'b0}}};
    end else begin
      out_sat = {1'b0, {(SB-1){1'b1}}};
    end
  end

  // result queue
  logic [rgrf_pkg::OUT_W-1:0] q_rd;
  logic [CW-1:0]              q_level;
  logic [CW-1:0]              q_used;

  assign q_used    = q_level + CW'(vb_r) + CW'(vc_r) + CW'(vd_r);
  assign credit_ok = q_used < CW'(rgrf_pkg::FIFO_DEPTH);

  rgrf_out_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (vd_r && emit_d_r),
    .wr_data  ({done_d_r, out_sat}),
    .rd_valid (out_tvalid),
    .rd_ready (out_tready),
    .rd_data  (q_rd),
    .level    (q_level)
  );

  assign out_tdata = rgrf_pkg::TDATA_W'(q_rd[SB-1:0]);
  assign out_tlast = q_rd[SB];

endmodule

`default_nettype wire

>>> tb/recursive_gaussian_row_filter_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for recursive_gaussian_row_filter: streams image rows under random
// backpressure and checks each blurred sample against an in-bench fixed-point predictor.
// Depends on rgrf_pkg and the filter RTL only.

module recursive_gaussian_row_filter_tb;
  import rgrf_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 12;
  localparam int ITEMS_PER_MODE = 160;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 16'sh8000;
  localparam coef_t COEF_MAX = 25'sh0FFFFFF;
  localparam coef_t COEF_MIN = 25'sh1000000;
  localparam coef_t COEF_ONE = 25'sh0400000;

  localparam longint SEC_HI = (64'sd1 <<< (SEC_W - 1)) - 1;
  localparam longint SEC_LO = -SEC_HI - 1;
  localparam longint OUT_HI = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint OUT_LO = -OUT_HI - 1;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          row_done;
  } blurred_t;

  class row_blur_scoreboard;
    logic [RAD_W-1:0]              radius;
    coef_t                         feed_gain[NUM_SEC];
    coef_t                         feedback_gain[NUM_SEC];
    logic signed [SAMPLE_BITS-1:0] row_history[DELAY_DEPTH];
    sec_t                          sec_y1[NUM_SEC];
    sec_t                          sec_y2[NUM_SEC];
    int unsigned                   row_pos;
    int unsigned                   hist_ptr;
    blurred_t                      expected_blur[$];
    int                            mismatches;
    int                            results_checked;

    function new();
      radius = 1;
      foreach (feed_gain[i]) begin
        feed_gain[i]     = '0;
        feedback_gain[i] = '0;
      end
      foreach (row_history[i]) row_history[i] = '0;
      mismatches      = 0;
      results_checked = 0;
      restart_row();
    endfunction

    function void restart_row();
      foreach (sec_y1[i]) begin
        sec_y1[i] = '0;
        sec_y2[i] = '0;
      end
      row_pos  = 0;
      hist_ptr = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
      case (idx)
        CFG_RADIUS: radius = data[RAD_W-1:0];
        CFG_FEED_1: feed_gain[0] = data;
        CFG_FEED_3: feed_gain[1] = data;
        CFG_FEED_5: feed_gain[2] = data;
        CFG_FB_1:   feedback_gain[0] = data;
        CFG_FB_3:   feedback_gain[1] = data;
        CFG_FB_5:   feedback_gain[2] = data;
        default: ;
      endcase
    endfunction

    // c * v / 2^22, rounded half up
    function longint q22_product(coef_t c, longint v);
      logic signed [79:0] p;
      p = c;
      p = p * v + (80'sd1 <<< (FRAC_W - 1));
      return longint'(p >>> FRAC_W);
    endfunction

    function void note_sample(logic signed [SAMPLE_BITS-1:0] x, logic row_end);
      int unsigned r;
      int unsigned steps;
      int unsigned back;
      int          produced;
      longint      lhs;
      longint      y;
      longint      sum;
      longint      o;
      blurred_t    e;
      logic signed [SAMPLE_BITS-1:0] left;
      r = (radius == 0) ? 1 : ((radius > MAX_RADIUS) ? MAX_RADIUS : radius);
      steps = row_end ? r : 1;
      produced = 0;
      for (int unsigned j = 0; j < steps; j++) begin
        left = '0;
        if (row_pos + j >= 2 * r) begin
          back = 2 * r - j;
          left = row_history[(hist_ptr + DELAY_DEPTH - back) % DELAY_DEPTH];
        end
        lhs = (longint'(left) + ((j == 0) ? longint'(x) : 64'sd0)) <<< SEC_FRAC;
        sum = 0;
        for (int i = 0; i < NUM_SEC; i++) begin
          y = q22_product(feed_gain[i], lhs) - q22_product(feedback_gain[i], sec_y1[i])
              - sec_y2[i];
          if (y > SEC_HI) y = SEC_HI;
          else if (y < SEC_LO) y = SEC_LO;
          sec_y2[i] = sec_y1[i];
          sec_y1[i] = sec_t'(y);
          sum += y;
        end
        if (row_pos + j + 1 >= r) begin
          o = (sum + (64'sd1 <<< (SEC_FRAC - 1))) >>> SEC_FRAC;
          if (o > OUT_HI) o = OUT_HI;
          else if (o < OUT_LO) o = OUT_LO;
          e.sample_out = o[SAMPLE_BITS-1:0];
          e.row_done   = 1'b0;
          expected_blur.push_back(e);
          produced++;
        end
      end
      row_history[hist_ptr] = x;
      hist_ptr = (hist_ptr + 1) % DELAY_DEPTH;
      if (row_end) begin
        if (produced > 0) expected_blur[expected_blur.size() - 1].row_done = 1'b1;
        restart_row();
      end else if (row_pos < POS_CAP) begin
        row_pos++;
      end
    endfunction

    function void check_result(logic signed [SAMPLE_BITS-1:0] got, logic got_done);
      blurred_t want;
      if (expected_blur.size() == 0) begin
        $error("unexpected transfer: sample_out %0d row_done %0b", got, got_done);
        mismatches++;
        return;
      end
      want = expected_blur.pop_front();
      if (got !== want.sample_out) begin
        $error("sample_out: expected %0d, actual %0d", want.sample_out, got);
        mismatches++;
      end
      if (got_done !== want.row_done) begin
        $error("row_done: expected %0b, actual %0b", want.row_done, got_done);
        mismatches++;
      end
      results_checked++;
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [TDATA_W-1:0]    in_tdata;   // [15:0] sample_in
  logic                  in_tlast;   // row_end
  logic                  out_tvalid;
  logic                  out_tready;
  logic [TDATA_W-1:0]    out_tdata;  // [15:0] sample_out
  logic                  out_tlast;  // row_done
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [COEF_W-1:0]     cfg_data;

  row_blur_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int samples_in;
  int rows_in;
  int cfg_writes;
  int quiet_cycles;

  recursive_gaussian_row_filter u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // transfer monitor and watchdog
  always @(posedge clk) begin
    bit moved;
    moved = 1'b0;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        sb.write_reg(cfg_index, cfg_data);
        cfg_writes++;
        moved = 1'b1;
      end
      if (in_tvalid && in_tready) begin
        sb.note_sample($signed(in_tdata[SAMPLE_BITS-1:0]), in_tlast);
        samples_in++;
        if (in_tlast) rows_in++;
        moved = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        sb.check_result($signed(out_tdata[SAMPLE_BITS-1:0]), out_tlast);
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer in %0d cycles", WATCHDOG_LIMIT);
        $display("recursive_gaussian_row_filter regression: fail");
        $finish;
      end
    end
  end

  task automatic send_sample(logic signed [SAMPLE_BITS-1:0] x, logic row_end);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= x;
    in_tlast  <= row_end;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.expected_blur.size() != 0);
  endtask

  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves cfg_valid high so back-to-back writes need no re-arm
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_filter(logic [COEF_W-1:0] rad_word, coef_t f1, coef_t f3, coef_t f5,
                                coef_t b1, coef_t b3, coef_t b5);
    write_reg(CFG_RADIUS, rad_word);
    write_reg(CFG_FEED_1, f1);
    write_reg(CFG_FEED_3, f3);
    write_reg(CFG_FEED_5, f5);
    write_reg(CFG_FB_1, b1);
    write_reg(CFG_FB_3, b3);
    write_reg(CFG_FB_5, b5);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(15))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2, 3:    return SAMPLE_BITS'(int'($urandom_range(0, 200)) - 100);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // wild: any 25-bit value; else a value within +-span
  function automatic coef_t rand_coef(bit wild, int span);
    if (wild) return coef_t'($urandom);
    return coef_t'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic random_phase(int budget);
    int placed;
    int len;
    int eff;
    int r;
    int rows_left;
    bit wild;
    logic [COEF_W-1:0] rad_word;
    placed = 0;
    while (placed < budget) begin
      settle();
      case ($urandom_range(9))
        0:       r = MAX_RADIUS;
        1:       r = 0;
        2:       r = $urandom_range(MAX_RADIUS + 1, (1 << RAD_W) - 1);
        3:       r = $urandom_range(9, MAX_RADIUS - 1);
        default: r = $urandom_range(1, 8);
      endcase
      eff = (r < 1) ? 1 : ((r > MAX_RADIUS) ? MAX_RADIUS : r);
      rad_word = COEF_W'($urandom);
      rad_word[RAD_W-1:0] = RAD_W'(r);
      wild = ($urandom_range(3) == 0);
      program_filter(rad_word,
                     rand_coef(wild, 1 << 18), rand_coef(wild, 1 << 18),
                     rand_coef(wild, 1 << 18), rand_coef(wild, 1 << 23),
                     rand_coef(wild, 1 << 23), rand_coef(wild, 1 << 23));
      rows_left = $urandom_range(2, 6);
      while (rows_left > 0 && placed < budget) begin
        if ($urandom_range(9) == 0) drain();
        if ($urandom_range(15) == 0) len = POS_CAP + $urandom_range(1, 10);
        else begin
          case ($urandom_range(7))
            0:       len = 1;
            1:       len = eff;
            default: len = $urandom_range(1, 3 * eff + 2);
          endcase
        end
        for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
        placed += len;
        rows_left--;
      end
    end
  endtask

  initial begin
    sb = new();
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tlast      = 1'b0;
    out_tready    = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_RADIUS;
    cfg_data      = '0;
    send_idle_pct = 26;
    recv_idle_pct = 83;
    samples_in    = 0;
    rows_in       = 0;
    cfg_writes    = 0;
    quiet_cycles  = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset configuration: radius 1, all gains zero
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);
    settle();

    // extreme gains force section and output saturation; includes rows shorter than the radius
    program_filter(25'd3, COEF_MAX, COEF_MIN, COEF_ONE, COEF_MIN, COEF_MAX, '0);
    send_sample(SAMPLE_MIN, 1'b1);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);
    settle();

    // unused index is ignored; radius zero clamps to one
    write_reg(CFG_UNUSED_IDX, '1);
    write_reg(CFG_RADIUS, {{(COEF_W - RAD_W){1'b1}}, {RAD_W{1'b0}}});
    cfg_valid <= 1'b0;
    send_sample(16'sd100, 1'b0);
    send_sample(-16'sd100, 1'b0);
    send_sample(16'sd12345, 1'b1);
    settle();

    // radius above the maximum clamps to it; short row flushes every output
    program_filter(25'd63, rand_coef(0, 1 << 18), rand_coef(0, 1 << 18),
                   rand_coef(0, 1 << 18), rand_coef(0, 1 << 23),
                   rand_coef(0, 1 << 23), rand_coef(0, 1 << 23));
    for (int i = 0; i < 4; i++) send_sample(pick_sample(), i == 3);
    settle();

    // radius changed inside a row
    program_filter(25'd2, rand_coef(0, 1 << 18), rand_coef(0, 1 << 18),
                   rand_coef(0, 1 << 18), rand_coef(0, 1 << 23),
                   rand_coef(0, 1 << 23), rand_coef(0, 1 << 23));
    for (int i = 0; i < 4; i++) send_sample(pick_sample(), 1'b0);
    settle();
    write_reg(CFG_RADIUS, 25'd5);
    cfg_valid <= 1'b0;
    for (int i = 0; i < 3; i++) send_sample(pick_sample(), i == 2);

    for (int m = 0; m < 3; m++) begin
      case (m)
        0: begin
          send_idle_pct = 26;
          recv_idle_pct = 83;
        end
        1: begin
          send_idle_pct = 83;
          recv_idle_pct = 26;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      random_phase(ITEMS_PER_MODE);
    end
    settle();

    $display("covered %0d rows, %0d samples in, %0d blurred samples checked, %0d reg writes",
             rows_in, samples_in, sb.results_checked, cfg_writes);
    $display("radius 1..32 incl. clamped settings, saturating and stable gains, three idle mixes");
    if (sb.mismatches == 0) begin
      $display("recursive_gaussian_row_filter regression: pass");
    end else begin
      $display("recursive_gaussian_row_filter regression: fail");
    end
    $finish;
  end

endmodule
